// ===== hw/rtl/lidar_scan_packet_parser_defines.svh =====
// Shared assertion macros for the lidar scan packet parser.
`ifndef LIDAR_SCAN_PACKET_PARSER_DEFINES_SVH
`define LIDAR_SCAN_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define LSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsp assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define LSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsp assertion failed");

`endif

// ===== hw/rtl/lsp_pkg.sv =====
package lsp_pkg;
	localparam int JQ_DEPTH_DEF = 2;

	localparam logic [7:0] HDR_BYTE0  = 8'hAA;
	localparam logic [7:0] HDR_BYTE1  = 8'h55;
	localparam logic [2:0] ANG_LAST   = 3'd5;
	localparam logic [2:0] ANG_FSA_HI = 3'd1;
	localparam logic [2:0] ANG_LSA_HI = 3'd3;
	localparam logic [8:0] DEG_MAX    = 9'd360;
	localparam int DIV_STEPS = 24;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic [14:0] fsa;
		logic [14:0] lsa;
		logic [7:0]  idx;
		logic [7:0]  total;
		logic [13:0] sdist;
		logic        last;
	} lsp_job_t;
endpackage

// ===== hw/rtl/lsp_front.sv =====
module lsp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       rx_byte,
	input  logic             jq_full,
	output logic             full,
	output logic             job_push,
	output lsp_pkg::lsp_job_t job
);
	import lsp_pkg::*;

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_SYNC2   = 6'b000010,
		PH_TYPE    = 6'b000100,
		PH_COUNT   = 6'b001000,
		PH_ANGLES  = 6'b010000,
		PH_SAMPLES = 6'b100000
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  fcnt_q;
	logic [7:0]  total_q;
	logic [7:0]  idx_q;
	logic [14:0] fsa_q;
	logic [14:0] lsa_q;
	logic [7:0]  low_q;

	logic        accept;
	logic [15:0] word;
	logic        last;

	assign full   = jq_full;
	assign accept = push && !jq_full;
	assign word   = {rx_byte, low_q};
	assign last   = (({1'b0, idx_q} + 9'd1) >= {1'b0, total_q});

	assign job_push  = accept && (phase_q == PH_SAMPLES) && (fcnt_q != 3'd0);
	assign job.fsa   = fsa_q;
	assign job.lsa   = lsa_q;
	assign job.idx   = idx_q;
	assign job.total = total_q;
	assign job.sdist = word[15:2];
	assign job.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fcnt_q  <= 3'd0;
			total_q <= 8'd0;
			idx_q   <= 8'd0;
			fsa_q   <= 15'd0;
			lsa_q   <= 15'd0;
			low_q   <= 8'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == HDR_BYTE0)
						phase_q <= PH_SYNC2;
				end
				PH_SYNC2: begin
					if (rx_byte == HDR_BYTE1)
						phase_q <= PH_TYPE;
					else if (rx_byte != HDR_BYTE0)
						phase_q <= PH_HUNT;
				end
				PH_TYPE: begin
					phase_q <= rx_byte[0] ? PH_HUNT : PH_COUNT;
				end
				PH_COUNT: begin
					total_q <= rx_byte;
					idx_q   <= 8'd0;
					fcnt_q  <= 3'd0;
					phase_q <= PH_ANGLES;
				end
				PH_ANGLES: begin
					if (fcnt_q == ANG_FSA_HI)
						fsa_q <= word[15:1];
					if (fcnt_q == ANG_LSA_HI)
						lsa_q <= word[15:1];
					low_q <= rx_byte;
					if (fcnt_q >= ANG_LAST) begin
						fcnt_q  <= 3'd0;
						idx_q   <= 8'd0;
						phase_q <= (total_q == 8'd0) ? PH_HUNT : PH_SAMPLES;
					end else begin
						fcnt_q <= fcnt_q + 3'd1;
					end
				end
				PH_SAMPLES: begin
					if (fcnt_q == 3'd0) begin
						low_q  <= rx_byte;
						fcnt_q <= 3'd1;
					end else begin
						fcnt_q <= 3'd0;
						if (last) begin
							idx_q   <= 8'd0;
							phase_q <= PH_HUNT;
						end else begin
							idx_q <= idx_q + 8'd1;
						end
					end
				end
				default: begin
					phase_q <= PH_HUNT;
					fcnt_q  <= 3'd0;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/lsp_job_fifo.sv =====
module lsp_job_fifo #(
	parameter int DEPTH = lsp_pkg::JQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsp_pkg::lsp_job_t din,
	output logic              full,
	input  logic              pop,
	output lsp_pkg::lsp_job_t dout,
	output logic              empty
);
	import lsp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	lsp_job_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== hw/rtl/lsp_back.sv =====
module lsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              jq_empty,
	input  lsp_pkg::lsp_job_t job,
	output logic              jq_pop,
	input  logic              pop,
	output logic              empty,
	output logic [8:0]        angle_deg,
	output logic              in_range,
	output logic [13:0]       distance,
	output logic              last_in_packet
);
	import lsp_pkg::*;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MUL  = 5'b00010,
		B_DIV  = 5'b00100,
		B_ADJ  = 5'b01000,
		B_OUT  = 5'b10000
	} bstate_t;

	bstate_t            st_q;
	logic [14:0]        fsa_q;
	logic signed [15:0] diff_q;
	logic [7:0]         idx_q;
	logic [7:0]         div_q;
	logic               single_q;
	logic [13:0]        dist_q;
	logic               last_q;
	logic               neg_q;
	logic [23:0]        quo_q;
	logic [8:0]         rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [24:0] qs_q;
	logic               ov_q;
	logic [8:0]         deg_q;
	logic               rng_q;
	logic [13:0]        odist_q;
	logic               olast_q;

	logic signed [24:0] prod;
	logic [24:0]        prod_mag;
	logic [8:0]         rem_sh;
	logic               ge;
	logic [24:0]        qmag;
	logic signed [25:0] asum;
	logic [8:0]         deg;
	logic               load;

	assign prod     = diff_q * $signed({1'b0, idx_q});
	assign prod_mag = prod[24] ? 25'(-prod) : 25'(prod);
	assign rem_sh   = {rem_q[7:0], quo_q[23]};
	assign ge       = (rem_sh >= {1'b0, div_q});
	assign qmag     = {1'b0, quo_q} + {24'd0, neg_q && (rem_q != 9'd0)};
	assign asum     = $signed({11'd0, fsa_q}) + $signed({qs_q[24], qs_q});
	assign deg      = asum[25] ? 9'd0 : asum[14:6];
	assign load     = (st_q == B_OUT) && (!ov_q || pop);

	assign jq_pop         = (st_q == B_IDLE) && !jq_empty;
	assign empty          = !ov_q;
	assign angle_deg      = deg_q;
	assign in_range       = rng_q;
	assign distance       = odist_q;
	assign last_in_packet = olast_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				fsa_q    <= job.fsa;
				diff_q   <= $signed({1'b0, job.lsa}) - $signed({1'b0, job.fsa});
				idx_q    <= job.idx;
				div_q    <= job.total - 8'd1;
				single_q <= (job.total <= 8'd1);
				dist_q   <= job.sdist;
				last_q   <= job.last;
			end
			B_MUL: begin
				neg_q <= prod[24] && !single_q;
				quo_q <= single_q ? 24'd0 : prod_mag[23:0];
				rem_q <= 9'd0;
				cnt_q <= CNT_W'(DIV_STEPS);
			end
			B_DIV: begin
				quo_q <= {quo_q[22:0], ge};
				rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
				cnt_q <= cnt_q - 1'b1;
			end
			B_ADJ: begin
				qs_q <= neg_q ? $signed(-qmag) : $signed(qmag);
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
		if (load) begin
			deg_q   <= deg;
			rng_q   <= (deg <= DEG_MAX);
			odist_q <= dist_q;
			olast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (load)
				ov_q <= 1'b1;
			else if (pop)
				ov_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (!jq_empty)
						st_q <= B_MUL;
				end
				B_MUL: begin
					st_q <= single_q ? B_ADJ : B_DIV;
				end
				B_DIV: begin
					if (cnt_q == CNT_W'(1))
						st_q <= B_ADJ;
				end
				B_ADJ: begin
					st_q <= B_OUT;
				end
				B_OUT: begin
					if (load)
						st_q <= B_IDLE;
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/lidar_scan_packet_parser.sv =====
// Lidar scan packet parser.
// Input channel: push/full carry one received byte (rx_byte) per beat. Packets
// start with 0xAA 0x55, a type byte (odd types dropped), a sample count, the
// start and end angle words and a checksum word; each two-byte sample after
// that yields one result beat.
// Result channel: empty/pop; angle_deg, in_range, distance and last_in_packet
// of the oldest result stand on the ports while empty is low.
// Header, angle and first sample bytes are taken at one per cycle while full is
// low. A sample's second byte hands a job to a JQ_DEPTH-entry queue; the back
// end then reads it from the queue, multiplies, runs 24 restoring divide steps,
// fixes the sign and adds the angle (the divide is skipped when the packet holds
// one sample), and loads the result into the output register. The bit-serial
// divider bounds throughput: the back end reads the next job only after that
// load. full rises while the job queue is full.
// When the receiver stalls, the result holds in the output register, the back
// end waits with the next finished sample, and the queue then fills and raises
// full. Reset (arst_n low) returns the parser to header hunt and empties the
// queue and the output register.
module lidar_scan_packet_parser #(
	parameter int JQ_DEPTH = lsp_pkg::JQ_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [8:0]  angle_deg,
	output logic        in_range,
	output logic [13:0] distance,
	output logic        last_in_packet
);
	import lsp_pkg::*;

	lsp_job_t job_in;
	lsp_job_t job_out;
	logic     job_push;
	logic     jq_full;
	logic     jq_empty;
	logic     jq_pop;

	lsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.jq_full  (jq_full),
		.full     (full),
		.job_push (job_push),
		.job      (job_in)
	);

	lsp_job_fifo #(
		.DEPTH (JQ_DEPTH)
	) u_jq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (jq_full),
		.pop    (jq_pop),
		.dout   (job_out),
		.empty  (jq_empty)
	);

	lsp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.jq_empty       (jq_empty),
		.job            (job_out),
		.jq_pop         (jq_pop),
		.pop            (pop),
		.empty          (empty),
		.angle_deg      (angle_deg),
		.in_range       (in_range),
		.distance       (distance),
		.last_in_packet (last_in_packet)
	);
endmodule

// ===== hw/rtl/lsp_checker.sv =====
`include "lidar_scan_packet_parser_defines.svh"

module lsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [8:0]  angle_deg,
	input logic        in_range,
	input logic [13:0] distance,
	input logic        last_in_packet
);
	logic [24:0] res_bus;

	assign res_bus = {angle_deg, in_range, distance, last_in_packet};

	`LSP_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(res_bus))
	`LSP_ASSERT_IMP(a_range_flag, !empty, in_range == (angle_deg <= 9'd360))
	`LSP_ASSERT_IMP(a_drain_by_pop, $rose(empty), $past(pop))
endmodule

bind lidar_scan_packet_parser lsp_checker u_lsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.angle_deg      (angle_deg),
	.in_range       (in_range),
	.distance       (distance),
	.last_in_packet (last_in_packet)
);

// ===== test/tb_lidar_scan_packet_parser.sv =====
`timescale 1ns / 1ps

module tb_lidar_scan_packet_parser;
	import lsp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int BYTES_PER_MIX = 480;
	localparam int DRAIN_CYCLES = 64;

	typedef enum logic [2:0] {
		P_HUNT,
		P_SYNC2,
		P_TYPE,
		P_COUNT,
		P_ANGLES,
		P_SAMPLES
	} parse_phase_t;

	typedef struct packed {
		logic [8:0]  angle;
		logic        ok;
		logic [13:0] sdist;
		logic        is_last;
	} sample_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [8:0]  angle_deg;
	logic        in_range;
	logic [13:0] distance;
	logic        last_in_packet;

	lidar_scan_packet_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.angle_deg(angle_deg),
		.in_range(in_range),
		.distance(distance),
		.last_in_packet(last_in_packet)
	);

	always #5 clk = ~clk;

	logic [7:0]   rx_bytes_q[$];
	sample_beat_t samples_due_q[$];
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           bytes_queued = 0;
	int           bytes_taken = 0;
	int           samples_seen = 0;
	int           packets_sent = 0;
	int           mismatches = 0;
	int           cycles = 0;

	parse_phase_t phase = P_HUNT;
	logic [2:0]   fld_cnt = '0;
	logic [7:0]   n_samples = '0;
	logic [7:0]   smp_idx = '0;
	logic [14:0]  ang_start = '0;
	logic [14:0]  ang_end = '0;
	logic [7:0]   lo_byte = '0;

	task automatic track_byte(input logic [7:0] b);
		logic [15:0]  word;
		int           fsa;
		int           lsa;
		int           a;
		int           p;
		int           m;
		int           q;
		logic [8:0]   deg;
		logic         is_last;
		sample_beat_t r;
		word = {b, lo_byte};
		case (phase)
			P_HUNT: begin
				if (b == HDR_BYTE0)
					phase = P_SYNC2;
			end
			P_SYNC2: begin
				if (b == HDR_BYTE1)
					phase = P_TYPE;
				else if (b != HDR_BYTE0)
					phase = P_HUNT;
			end
			P_TYPE: begin
				phase = b[0] ? P_HUNT : P_COUNT;
			end
			P_COUNT: begin
				n_samples = b;
				smp_idx = '0;
				fld_cnt = '0;
				phase = P_ANGLES;
			end
			P_ANGLES: begin
				if (fld_cnt == ANG_FSA_HI)
					ang_start = word[15:1];
				else if (fld_cnt == ANG_LSA_HI)
					ang_end = word[15:1];
				lo_byte = b;
				if (fld_cnt >= ANG_LAST) begin
					fld_cnt = '0;
					smp_idx = '0;
					phase = (n_samples == 8'd0) ? P_HUNT : P_SAMPLES;
				end else begin
					fld_cnt = fld_cnt + 3'd1;
				end
			end
			P_SAMPLES: begin
				if (fld_cnt == 3'd0) begin
					lo_byte = b;
					fld_cnt = 3'd1;
				end else begin
					fsa = int'(ang_start);
					lsa = int'(ang_end);
					a = fsa;
					is_last = (int'(smp_idx) + 1 >= int'(n_samples));
					if (n_samples > 8'd1) begin
						p = (lsa - fsa) * int'(smp_idx);
						m = int'(n_samples) - 1;
						q = p / m;
						if ((p % m) != 0 && p < 0)
							q = q - 1;
						a = fsa + q;
					end
					if (a < 0)
						a = 0;
					deg = a[14:6];
					r.angle = deg;
					r.ok = (deg <= DEG_MAX);
					r.sdist = word[15:2];
					r.is_last = is_last;
					samples_due_q.push_back(r);
					fld_cnt = '0;
					if (is_last) begin
						smp_idx = '0;
						phase = P_HUNT;
					end else begin
						smp_idx = smp_idx + 8'd1;
					end
				end
			end
			default: begin
				phase = P_HUNT;
				fld_cnt = '0;
			end
		endcase
	endtask

	task automatic add_byte(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_queued++;
	endtask

	task automatic add_word(input logic [15:0] w);
		add_byte(w[7:0]);
		add_byte(w[15:8]);
	endtask

	task automatic add_traffic(input int n_bytes);
		int          stop_at;
		int          pick;
		int          n;
		int          cut;
		logic [15:0] fsa_w;
		logic [15:0] lsa_w;
		logic [15:0] smp;
		stop_at = bytes_queued + n_bytes;
		while (bytes_queued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 7) begin
				repeat ($urandom_range(1, 4))
					add_byte(8'($urandom_range(255)));
				continue;
			end
			packets_sent++;
			add_byte(HDR_BYTE0);
			if (pick < 12)
				repeat ($urandom_range(1, 3))
					add_byte(HDR_BYTE0);
			add_byte(HDR_BYTE1);
			if (pick < 17) begin
				add_byte({7'($urandom_range(127)), 1'b1});
				continue;
			end
			add_byte({7'($urandom_range(127)), 1'b0});
			pick = $urandom_range(99);
			if (pick < 5)
				n = 0;
			else if (pick < 85)
				n = $urandom_range(1, 8);
			else if (pick < 98)
				n = $urandom_range(9, 40);
			else
				n = $urandom_range(100, 255);
			add_byte(8'(n));
			if ($urandom_range(99) < 70) begin
				fsa_w = 16'($urandom_range(0, 360 * 64) * 2 + $urandom_range(1));
				lsa_w = fsa_w + 16'($urandom_range(0, 40 * 64) * 2);
				if ($urandom_range(99) < 20)
					lsa_w = 16'($urandom_range(0, 360 * 64) * 2);
			end else begin
				fsa_w = 16'($urandom_range(16'hFFFF));
				lsa_w = 16'($urandom_range(16'hFFFF));
			end
			add_word(fsa_w);
			add_word(lsa_w);
			add_word(16'($urandom_range(16'hFFFF)));
			cut = ($urandom_range(99) < 4) ? $urandom_range(0, n) : n;
			for (int i = 0; i < cut; i++) begin
				pick = $urandom_range(99);
				if (pick < 5)
					smp = 16'h0000;
				else if (pick < 10)
					smp = 16'hFFFF;
				else if (pick < 13)
					smp = {HDR_BYTE1, HDR_BYTE0};
				else
					smp = 16'($urandom_range(16'hFFFF));
				add_word(smp);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				track_byte(rx_byte);
				bytes_taken++;
			end
			if (!push || !full) begin
				if (rx_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					rx_byte <= rx_bytes_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		sample_beat_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				samples_seen++;
				if (samples_due_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat angle=%0d dist=%0d",
						angle_deg, distance));
				end else begin
					want = samples_due_q.pop_front();
					if (angle_deg !== want.angle || in_range !== want.ok ||
						distance !== want.sdist || last_in_packet !== want.is_last)
						report_mismatch($sformatf(
							"exp angle=%0d ok=%0b dist=%0d last=%0b, got %0d %0b %0d %0b",
							want.angle, want.ok, want.sdist, want.is_last,
							angle_deg, in_range, distance, last_in_packet));
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still due",
				cycles, samples_due_q.size());
			$display("lidar_scan_packet_parser test failed");
			$finish;
		end
	end

	initial begin
		int send_mix[4];
		int recv_mix[4];
		send_mix = '{0, 82, 0, 18};
		recv_mix = '{0, 0, 82, 18};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// hunt noise, repeated sync byte, dropped odd type
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(HDR_BYTE0);
		add_byte(HDR_BYTE0);
		add_byte(HDR_BYTE1);
		add_byte(8'h01);
		// empty packet
		add_byte(HDR_BYTE0);
		add_byte(HDR_BYTE1);
		add_byte(8'h00);
		add_byte(8'h00);
		add_word(16'h0000);
		add_word(16'hFFFF);
		add_word(16'h3412);
		// single sample, angle past 360, sync bytes as sample data
		add_byte(HDR_BYTE0);
		add_byte(HDR_BYTE1);
		add_byte(8'hFE);
		add_byte(8'h01);
		add_word(16'hFFFF);
		add_word(16'h0000);
		add_word(16'h0000);
		add_byte(HDR_BYTE0);
		add_byte(HDR_BYTE1);

		for (int k = 0; k < 4; k++) begin
			send_idle_pct = send_mix[k];
			recv_stall_pct = recv_mix[k];
			add_traffic(BYTES_PER_MIX);
			while (bytes_taken < bytes_queued)
				@(posedge clk);
			while (samples_due_q.size() > 0)
				@(posedge clk);
		end
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d packet starts, checked %0d sample beats",
			bytes_taken, packets_sent, samples_seen);
		$display("mixes: free-running, sender gaps, receiver stalls, both; %0d mismatches",
			mismatches);
		if (mismatches == 0 && samples_due_q.size() == 0) begin
			$display("lidar_scan_packet_parser test passed");
		end else begin
			$display("lidar_scan_packet_parser test failed");
		end
		$finish;
	end
endmodule

// ===== lidar_scan_packet_parser.f =====
+incdir+hw/rtl
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_front.sv
hw/rtl/lsp_job_fifo.sv
hw/rtl/lsp_back.sv
hw/rtl/lidar_scan_packet_parser.sv
hw/rtl/lsp_checker.sv
test/tb_lidar_scan_packet_parser.sv
